// ----- sv/qhdp_pkg.sv -----
// ----------------------------------------------------------------------------
// qhdp_pkg: shared constants and helpers for the demand peak tracker
// Window length, datapath widths, register indexes, saturation and divisor helpers.
// ----------------------------------------------------------------------------
package qhdp_pkg;

    localparam int WINDOW_SECONDS = 900;
    localparam int VOLTS          = 230;
    localparam int DECI           = 10;

    // seconds counter holds 0 .. WINDOW_SECONDS, the top value only while the average is formed
    localparam int CNT_W  = $clog2(WINDOW_SECONDS);
    localparam int LEFT_W = $clog2(WINDOW_SECONDS + 1);
    localparam int SEC_W  = 10;
    localparam int LIM_W  = 31;
    localparam int SUM_W  = CNT_W + 32;
    localparam int PROD_W = LIM_W + CNT_W;
    localparam int BUD_W  = SUM_W + 1;
    localparam int DMUL_W = 36;
    localparam int DVD_W  = (BUD_W - 1 > DMUL_W) ? BUD_W - 1 : DMUL_W;
    localparam int DVS_W  = (LEFT_W > 10) ? LEFT_W : 10;
    localparam int CFG_W  = 31;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_COUNT = 1'd1;

    // saturate a sign/magnitude quotient to int32
    function automatic logic signed [31:0] sat_s32(input logic neg,
                                                   input logic [DVD_W-1:0] mag);
        logic signed [31:0] res;
        if (neg) begin
            if (mag > DVD_W'(32'h8000_0000))
                res = 32'sh8000_0000;
            else
                res = -$signed(mag[31:0]);
        end
        else begin
            if (mag > DVD_W'(32'h7FFF_FFFF))
                res = 32'sh7FFF_FFFF;
            else
                res = $signed(mag[31:0]);
        end
        return res;
    endfunction

    // saturate a sign/magnitude quotient to int16
    function automatic logic signed [15:0] sat_s16(input logic neg,
                                                   input logic [DVD_W-1:0] mag);
        logic signed [15:0] res;
        if (neg) begin
            if (mag > DVD_W'(16'h8000))
                res = 16'sh8000;
            else
                res = -$signed(mag[15:0]);
        end
        else begin
            if (mag > DVD_W'(16'h7FFF))
                res = 16'sh7FFF;
            else
                res = $signed(mag[15:0]);
        end
        return res;
    endfunction

    // volts times phases, the deciamp divisor
    function automatic logic [DVS_W-1:0] phase_divisor(input logic [1:0] phases);
        logic [DVS_W-1:0] res;
        case (phases)
            2'd1:    res = DVS_W'(VOLTS);
            2'd2:    res = DVS_W'(VOLTS * 2);
            2'd3:    res = DVS_W'(VOLTS * 3);
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

// ----- sv/qhdp_if.sv -----
// ----------------------------------------------------------------------------
// qhdp_if: tick and result channels of the demand peak tracker
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface qhdp_tick_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] power_w;
    logic        [7:0]  month;
    logic        [7:0]  year_index;

    modport source (output valid, power_w, month, year_index, input ready);
    modport sink   (input valid, power_w, month, year_index, output ready);
endinterface

interface qhdp_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] window_average_w;
    logic               average_valid;
    logic               window_closed;
    logic        [30:0] peak_demand_w;
    logic        [9:0]  seconds_elapsed;
    logic signed [31:0] spare_power_w;
    logic signed [15:0] headroom_deciamps;

    modport source (output valid, window_average_w, average_valid, window_closed,
                    peak_demand_w, seconds_elapsed, spare_power_w, headroom_deciamps,
                    input ready);
    modport sink   (input valid, window_average_w, average_valid, window_closed,
                    peak_demand_w, seconds_elapsed, spare_power_w, headroom_deciamps,
                    output ready);
endinterface

// ----- sv/qhdp_divider.sv -----
// ----------------------------------------------------------------------------
// qhdp_divider: shared unsigned restoring divider
// One quotient bit per cycle; done pulses once the quotient is complete.
// ----------------------------------------------------------------------------
module qhdp_divider
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [qhdp_pkg::DVD_W-1:0] dividend,
    input  logic [qhdp_pkg::DVS_W-1:0] divisor,
    output logic                      done,
    output logic [qhdp_pkg::DVD_W-1:0] quotient
);
    import qhdp_pkg::*;

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DVS_W:0]    shifted;
    logic [DVS_W+1:0]  trial;
    logic              fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DVD_W-1]};
        trial   = {1'b0, shifted} - {2'b00, dvs_reg};
        fits    = !trial[DVS_W+1];

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = STEP_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shifted < 2*divisor, so the kept remainder fits DVS_W bits
            rem_next  = fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
            quo_next  = {quo_reg[DVD_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/quarter_hour_demand_peak_tracker.sv -----
// ----------------------------------------------------------------------------
// quarter_hour_demand_peak_tracker: 15-minute maximum demand meter
// Window energy sum, monthly peak, headroom and headroom current per tick.
// ----------------------------------------------------------------------------
// Datapath: one shared divider, 42 quotient steps. The window average is
//   divided out when the window closes, the headroom when a limit is set
//   mid-window, and the headroom current when phases are nonzero.
// Throughput: one tick at a time; the next is taken in the cycle after the
//   result is registered, later while it is stalled.
// Reset: asynchronous, active low; limit 0, one phase, all state cleared.
// ----------------------------------------------------------------------------
module quarter_hour_demand_peak_tracker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [qhdp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [qhdp_pkg::CFG_W-1:0]     cfg_data,
    qhdp_tick_if.sink                     tick,
    qhdp_result_if.source                 result
);
    import qhdp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AVG_GO,
        S_AVG_WAIT,
        S_HEAD_MUL,
        S_HEAD_SUB,
        S_HEAD_GO,
        S_HEAD_WAIT,
        S_DA_MUL,
        S_DA_GO,
        S_DA_WAIT,
        S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [LIM_W-1:0]          limit_reg, limit_next;
    logic [1:0]                phase_reg, phase_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [31:0]        avg_reg, avg_next;
    logic                      seen_reg, seen_next;
    logic [30:0]               peak_reg, peak_next;
    logic [7:0]                mtag_reg, mtag_next;
    logic [7:0]                ytag_reg, ytag_next;
    logic                      closed_reg, closed_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic signed [BUD_W-1:0]   budget_reg, budget_next;
    logic signed [31:0]        head_reg, head_next;
    logic signed [DMUL_W-1:0]  dmul_reg, dmul_next;
    logic signed [15:0]        da_reg, da_next;
    logic                      neg_reg, neg_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [31:0]        out_avg_reg, out_avg_next;
    logic                      out_seen_reg, out_seen_next;
    logic                      out_closed_reg, out_closed_next;
    logic [30:0]               out_peak_reg, out_peak_next;
    logic [CNT_W-1:0]          out_sec_reg, out_sec_next;
    logic signed [31:0]        out_head_reg, out_head_next;
    logic signed [15:0]        out_da_reg, out_da_next;

    logic                      div_start;
    logic [DVD_W-1:0]          div_dividend;
    logic [DVS_W-1:0]          div_divisor;
    logic                      div_done;
    logic [DVD_W-1:0]          div_quotient;

    logic                      tick_take;
    logic [SUM_W-1:0]          sum_mag;
    logic [BUD_W-1:0]          bud_mag;
    logic [DMUL_W-1:0]         dmul_mag;
    logic signed [31:0]        avg_q;

    qhdp_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign tick_take = tick.valid && tick.ready;

    always_comb
    begin
        sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        bud_mag  = budget_reg[BUD_W-1] ? BUD_W'(-budget_reg) : BUD_W'(budget_reg);
        dmul_mag = dmul_reg[DMUL_W-1] ? DMUL_W'(-dmul_reg) : DMUL_W'(dmul_reg);
        avg_q    = sat_s32(neg_reg, div_quotient);

        state_next      = state_reg;
        limit_next      = limit_reg;
        phase_next      = phase_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        avg_next        = avg_reg;
        seen_next       = seen_reg;
        peak_next       = peak_reg;
        mtag_next       = mtag_reg;
        ytag_next       = ytag_reg;
        closed_next     = closed_reg;
        prod_next       = prod_reg;
        budget_next     = budget_reg;
        head_next       = head_reg;
        dmul_next       = dmul_reg;
        da_next         = da_reg;
        neg_next        = neg_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_avg_next    = out_avg_reg;
        out_seen_next   = out_seen_reg;
        out_closed_next = out_closed_reg;
        out_peak_next   = out_peak_reg;
        out_sec_next    = out_sec_reg;
        out_head_next   = out_head_reg;
        out_da_next     = out_da_reg;

        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;

        // the user must write configuration only while idle; the block does not enforce it
        if (cfg_write)
        begin
            case (cfg_index)
                REG_POWER_LIMIT: limit_next = cfg_data[LIM_W-1:0];
                REG_PHASE_COUNT: phase_next = cfg_data[1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (tick_take)
                begin
                    if (tick.month != mtag_reg || tick.year_index != ytag_reg)
                    begin
                        peak_next = '0;
                        mtag_next = tick.month;
                        ytag_next = tick.year_index;
                    end
                    sum_next    = sum_reg + SUM_W'(tick.power_w);
                    count_next  = count_reg + 1'b1;
                    closed_next = (count_reg == CNT_W'(WINDOW_SECONDS - 1));
                    state_next  = (count_reg == CNT_W'(WINDOW_SECONDS - 1)) ?
                                  S_AVG_GO : S_HEAD_MUL;
                end
            end
            S_AVG_GO:
            begin
                div_start    = 1'b1;
                div_dividend = DVD_W'(sum_mag);
                div_divisor  = DVS_W'(WINDOW_SECONDS);
                neg_next     = sum_reg[SUM_W-1];
                state_next   = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (div_done)
                begin
                    avg_next  = avg_q;
                    seen_next = 1'b1;
                    if (!avg_q[31] && avg_q[30:0] > peak_reg)
                        peak_next = avg_q[30:0];
                    sum_next   = '0;
                    count_next = '0;
                    state_next = S_HEAD_MUL;
                end
            end
            S_HEAD_MUL:
            begin
                if (limit_reg == '0)
                begin
                    head_next  = 32'sh7FFF_FFFF;
                    state_next = S_DA_MUL;
                end
                else if (count_reg == '0)
                begin
                    head_next  = $signed({1'b0, limit_reg});
                    state_next = S_DA_MUL;
                end
                else
                begin
                    prod_next  = PROD_W'(limit_reg) * PROD_W'(WINDOW_SECONDS);
                    state_next = S_HEAD_SUB;
                end
            end
            S_HEAD_SUB:
            begin
                budget_next = $signed({{(BUD_W-PROD_W){1'b0}}, prod_reg})
                            - BUD_W'(sum_reg);
                state_next  = S_HEAD_GO;
            end
            S_HEAD_GO:
            begin
                div_start    = 1'b1;
                div_dividend = DVD_W'(bud_mag);
                div_divisor  = DVS_W'(WINDOW_SECONDS) - DVS_W'(count_reg);
                neg_next     = budget_reg[BUD_W-1];
                state_next   = S_HEAD_WAIT;
            end
            S_HEAD_WAIT:
            begin
                if (div_done)
                begin
                    head_next  = avg_q;
                    state_next = S_DA_MUL;
                end
            end
            S_DA_MUL:
            begin
                if (phase_reg == 2'd0)
                begin
                    da_next    = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    // times ten as 8x + 2x
                    dmul_next  = (DMUL_W'(head_reg) <<< 3) + (DMUL_W'(head_reg) <<< 1);
                    state_next = S_DA_GO;
                end
            end
            S_DA_GO:
            begin
                div_start    = 1'b1;
                div_dividend = DVD_W'(dmul_mag);
                div_divisor  = phase_divisor(phase_reg);
                neg_next     = dmul_reg[DMUL_W-1];
                state_next   = S_DA_WAIT;
            end
            S_DA_WAIT:
            begin
                if (div_done)
                begin
                    da_next    = sat_s16(neg_reg, div_quotient);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_avg_next    = avg_reg;
                    out_seen_next   = seen_reg;
                    out_closed_next = closed_reg;
                    out_peak_next   = peak_reg;
                    out_sec_next    = count_reg;
                    out_head_next   = head_reg;
                    out_da_next     = da_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            limit_reg      <= '0;
            phase_reg      <= 2'd1;
            sum_reg        <= '0;
            count_reg      <= '0;
            avg_reg        <= '0;
            seen_reg       <= 1'b0;
            peak_reg       <= '0;
            mtag_reg       <= '0;
            ytag_reg       <= '0;
            closed_reg     <= 1'b0;
            prod_reg       <= '0;
            budget_reg     <= '0;
            head_reg       <= '0;
            dmul_reg       <= '0;
            da_reg         <= '0;
            neg_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_avg_reg    <= '0;
            out_seen_reg   <= 1'b0;
            out_closed_reg <= 1'b0;
            out_peak_reg   <= '0;
            out_sec_reg    <= '0;
            out_head_reg   <= '0;
            out_da_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            limit_reg      <= limit_next;
            phase_reg      <= phase_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
            avg_reg        <= avg_next;
            seen_reg       <= seen_next;
            peak_reg       <= peak_next;
            mtag_reg       <= mtag_next;
            ytag_reg       <= ytag_next;
            closed_reg     <= closed_next;
            prod_reg       <= prod_next;
            budget_reg     <= budget_next;
            head_reg       <= head_next;
            dmul_reg       <= dmul_next;
            da_reg         <= da_next;
            neg_reg        <= neg_next;
            out_valid_reg  <= out_valid_next;
            out_avg_reg    <= out_avg_next;
            out_seen_reg   <= out_seen_next;
            out_closed_reg <= out_closed_next;
            out_peak_reg   <= out_peak_next;
            out_sec_reg    <= out_sec_next;
            out_head_reg   <= out_head_next;
            out_da_reg     <= out_da_next;
        end
    end

    assign tick.ready               = (state_reg == S_IDLE);
    assign result.valid             = out_valid_reg;
    assign result.window_average_w  = out_avg_reg;
    assign result.average_valid     = out_seen_reg;
    assign result.window_closed     = out_closed_reg;
    assign result.peak_demand_w     = out_peak_reg;
    assign result.seconds_elapsed   = SEC_W'(out_sec_reg);
    assign result.spare_power_w     = out_head_reg;
    assign result.headroom_deciamps = out_da_reg;

    // a closed window restarts the count and always has an average
    a_close_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.window_closed |->
            result.seconds_elapsed == '0 && result.average_valid)
        else $error("closed window without restart or valid average");

    // count stays below the window length outside the average states
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(WINDOW_SECONDS) || state_reg == S_AVG_GO
            || state_reg == S_AVG_WAIT)
        else $error("second counter out of range");

    // one tick at a time
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        tick_take |=> !tick.ready)
        else $error("tick accepted while a tick is in flight");

    // no headroom when unlimited other than int32 max
    a_unlimited: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && limit_reg == '0 |-> head_reg == 32'sh7FFF_FFFF)
        else $error("unlimited headroom wrong");

endmodule

// ----- dv/tb_quarter_hour_demand_peak_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quarter_hour_demand_peak_tracker: self-checking bench for the demand meter
// Drives one-second ticks under several limit and phase settings and idle
// patterns. An in-bench predictor of the window sum, monthly peak and headroom
// checks every report field by field, in order.
// ----------------------------------------------------------------------------
module tb_quarter_hour_demand_peak_tracker;
    import qhdp_pkg::*;

    localparam int CYCLE_LIMIT        = 400_000;
    localparam int SETTLE_CYCLES      = 20;
    localparam int DRAIN_CYCLES       = 200;
    localparam int RANDOM_PHASE_TICKS = 86;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -S32_MAX - 1;
    localparam longint S16_MAX = 64'sd32767;
    localparam longint S16_MIN = -64'sd32768;

    typedef struct {
        logic signed [31:0] power_w;
        logic        [7:0]  month;
        logic        [7:0]  year_index;
    } tick_t;

    typedef struct {
        logic signed [31:0] window_average_w;
        logic               average_valid;
        logic               window_closed;
        logic        [30:0] peak_demand_w;
        logic        [9:0]  seconds_elapsed;
        logic signed [31:0] spare_power_w;
        logic signed [15:0] headroom_deciamps;
    } report_t;

    class demand_report_board;
        logic        [30:0] limit_w;
        logic        [1:0]  phases;
        logic signed [41:0] energy_ws;
        logic        [9:0]  secs;
        logic signed [31:0] last_avg;
        logic               avg_seen;
        logic        [30:0] peak_w;
        logic        [7:0]  month_tag;
        logic        [7:0]  year_tag;
        report_t            expected_reports[$];
        int                 errors;
        int                 closures;
        int                 ticks;

        function new();
            limit_w   = '0;
            phases    = 2'd1;
            energy_ws = '0;
            secs      = '0;
            last_avg  = '0;
            avg_seen  = 1'b0;
            peak_w    = '0;
            month_tag = '0;
            year_tag  = '0;
            errors    = 0;
            closures  = 0;
            ticks     = 0;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function report_t predict_report(tick_t t);
            report_t r;
            longint  sum_ws;
            longint  avg;
            longint  head;
            longint  budget;
            longint  left;
            longint  da;
            logic    closed;
            closed = 1'b0;
            // new month or year starts a fresh peak
            if (t.month != month_tag || t.year_index != year_tag) begin
                peak_w    = '0;
                month_tag = t.month;
                year_tag  = t.year_index;
            end
            sum_ws = longint'(energy_ws) + longint'(t.power_w);
            secs   = secs + 10'd1;
            if (int'(secs) >= WINDOW_SECONDS) begin
                avg      = clamp(sum_ws / WINDOW_SECONDS, S32_MIN, S32_MAX);
                last_avg = 32'(avg);
                avg_seen = 1'b1;
                if (avg > longint'(peak_w))
                    peak_w = 31'(avg);
                sum_ws   = 0;
                secs     = '0;
                closed   = 1'b1;
                closures++;
            end
            energy_ws = 42'(sum_ws);
            if (limit_w == '0)
                head = S32_MAX;
            else if (secs == '0)
                head = longint'(limit_w);
            else begin
                budget = longint'(limit_w) * WINDOW_SECONDS - sum_ws;
                left   = longint'(WINDOW_SECONDS) - longint'(secs);
                head   = clamp(budget / left, S32_MIN, S32_MAX);
            end
            da = 0;
            if (phases != 2'd0)
                da = clamp((head * DECI) / (longint'(VOLTS) * longint'(phases)),
                           S16_MIN, S16_MAX);
            r.window_average_w  = last_avg;
            r.average_valid     = avg_seen;
            r.window_closed     = closed;
            r.peak_demand_w     = peak_w;
            r.seconds_elapsed   = secs;
            r.spare_power_w     = 32'(head);
            r.headroom_deciamps = 16'(da);
            return r;
        endfunction

        function void note_tick(tick_t t);
            expected_reports.push_back(predict_report(t));
            ticks++;
        endfunction

        function void compare_field(string name, logic signed [63:0] e,
                                    logic signed [63:0] a);
            if (a !== e) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_report(report_t got);
            report_t e;
            if (expected_reports.size() == 0) begin
                $error("report with no tick outstanding");
                errors++;
                return;
            end
            e = expected_reports.pop_front();
            compare_field("window_average_w", e.window_average_w, got.window_average_w);
            compare_field("average_valid", e.average_valid, got.average_valid);
            compare_field("window_closed", e.window_closed, got.window_closed);
            compare_field("peak_demand_w", e.peak_demand_w, got.peak_demand_w);
            compare_field("seconds_elapsed", e.seconds_elapsed, got.seconds_elapsed);
            compare_field("spare_power_w", e.spare_power_w, got.spare_power_w);
            compare_field("headroom_deciamps", e.headroom_deciamps,
                          got.headroom_deciamps);
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    qhdp_tick_if   tick();
    qhdp_result_if result();

    quarter_hour_demand_peak_tracker i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick),
        .result    (result)
    );

    demand_report_board board = new();

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          settings       = 0;
    int unsigned cycle_count    = 0;
    logic [7:0]  cal_month;
    logic [7:0]  cal_year;
    report_t     seen_report;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        result.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready) begin
            seen_report.window_average_w  = result.window_average_w;
            seen_report.average_valid     = result.average_valid;
            seen_report.window_closed     = result.window_closed;
            seen_report.peak_demand_w     = result.peak_demand_w;
            seen_report.seconds_elapsed   = result.seconds_elapsed;
            seen_report.spare_power_w     = result.spare_power_w;
            seen_report.headroom_deciamps = result.headroom_deciamps;
            board.check_report(seen_report);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic tick_t make_tick(logic signed [31:0] p, logic [7:0] m,
                                        logic [7:0] y);
        tick_t t;
        t.power_w    = p;
        t.month      = m;
        t.year_index = y;
        return t;
    endfunction

    function automatic logic signed [31:0] draw_power(bit draw_down);
        int unsigned        pick;
        logic signed [31:0] p;
        pick = $urandom_range(99);
        if (pick < 65) begin
            p = 32'($urandom_range(20000));
            if (draw_down)
                p = -p;
        end
        else if (pick < 80)
            p = -$signed(32'($urandom_range(5000)));
        else if (pick < 92)
            p = $urandom;
        else begin
            case ($urandom_range(3))
                0:       p = 32'sh7FFF_FFFF;
                1:       p = 32'sh8000_0000;
                2:       p = 32'sd0;
                default: p = -32'sd1;
            endcase
        end
        return p;
    endfunction

    // calendar advances rarely, on one tick in 400 on average
    function automatic tick_t next_tick(bit draw_down);
        tick_t t;
        if ($urandom_range(399) == 0) begin
            if (cal_month == 8'd12) begin
                cal_month = 8'd1;
                cal_year  = cal_year + 8'd1;
            end
            else
                cal_month = cal_month + 8'd1;
        end
        t = make_tick(draw_power(draw_down), cal_month, cal_year);
        // stray calendar bytes now and then
        if ($urandom_range(199) == 0) begin
            t.month      = 8'($urandom);
            t.year_index = 8'($urandom);
        end
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            tick.valid <= 1'b0;
            @(posedge clk);
        end
        tick.valid      <= 1'b1;
        tick.power_w    <= t.power_w;
        tick.month      <= t.month;
        tick.year_index <= t.year_index;
        @(posedge clk);
        while (!tick.ready)
            @(posedge clk);
        board.note_tick(t);
    endtask

    // both registers, back to back, only while nothing is in flight
    task automatic set_config(input logic [30:0] limit, input logic [1:0] phases);
        cfg_write <= 1'b1;
        cfg_index <= REG_POWER_LIMIT;
        cfg_data  <= CFG_W'(limit);
        @(posedge clk);
        board.limit_w = limit;
        cfg_index <= REG_PHASE_COUNT;
        cfg_data  <= CFG_W'(phases);
        @(posedge clk);
        board.phases = phases;
        cfg_write <= 1'b0;
        settings++;
    endtask

    task automatic drain_reports(input int extra);
        tick.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic run_phase(input logic [30:0] limit, input logic [1:0] phases,
                             input int send_pct, input int recv_pct,
                             input bit draw_down);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        set_config(limit, phases);
        repeat (RANDOM_PHASE_TICKS) send_tick(next_tick(draw_down));
        drain_reports(SETTLE_CYCLES);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = REG_POWER_LIMIT;
        cfg_data        = '0;
        tick.valid      = 1'b0;
        tick.power_w    = '0;
        tick.month      = '0;
        tick.year_index = '0;
        cal_month       = 8'd1;
        cal_year        = 8'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unlimited; first request at month 0 / year 0 leaves the peak alone
        set_config(31'd0, 2'd1);
        send_tick(make_tick(32'sd0, 8'd0, 8'd0));
        send_tick(make_tick(32'sh7FFF_FFFF, 8'd0, 8'd0));
        send_tick(make_tick(32'sh8000_0000, 8'd0, 8'd0));
        send_tick(make_tick(-32'sd1, 8'd0, 8'd0));
        drain_reports(SETTLE_CYCLES);

        // largest limit, three phases: headroom saturates
        set_config(31'h7FFF_FFFF, 2'd3);
        send_tick(make_tick(32'sh7FFF_FFFF, 8'd255, 8'd0));
        send_tick(make_tick(32'sh7FFF_FFFF, 8'd255, 8'd255));
        send_tick(make_tick(32'sh8000_0000, 8'd255, 8'd255));
        send_tick(make_tick(32'sd1000, 8'd255, 8'd255));
        send_tick(make_tick(32'sd0, 8'd0, 8'd255));
        drain_reports(SETTLE_CYCLES);

        // tiny limit, zero phases: current forced to zero
        set_config(31'd1, 2'd0);
        send_tick(make_tick(32'sh8000_0000, 8'd1, 8'd0));
        send_tick(make_tick(32'sh7FFF_FFFF, 8'd1, 8'd0));
        send_tick(make_tick(-32'sd1, 8'd1, 8'd0));
        send_tick(make_tick(32'sd12000, 8'd1, 8'd0));
        drain_reports(SETTLE_CYCLES);

        set_config(31'd5000, 2'd2);
        send_tick(make_tick(32'sd4800, 8'd1, 8'd0));
        send_tick(make_tick(32'sh5555_5555, 8'hAA, 8'h55));
        send_tick(make_tick(32'shAAAA_AAAA, 8'h55, 8'hAA));
        send_tick(make_tick(32'sd6000, 8'd1, 8'd0));
        send_tick(make_tick(-32'sd3000, 8'd1, 8'd0));
        drain_reports(SETTLE_CYCLES);

        // random part: short phases, one per setting, covering each idle pattern
        run_phase(31'd0, 2'd1, 0, 0, 1'b0);
        run_phase(31'd9000, 2'd3, 85, 0, 1'b0);
        run_phase(31'h7FFF_FFFF, 2'd0, 0, 85, 1'b1);
        run_phase(31'd1, 2'd2, 37, 37, 1'b0);
        run_phase(31'd4000, 2'd1, 0, 0, 1'b0);

        drain_reports(DRAIN_CYCLES);
        $display("Checked %0d ticks across %0d register settings, %0d windows closed",
                 board.ticks, settings, board.closures);
        $display("Idle patterns: none, sender, receiver, both; limits 0 to max, 0-3 phases");
        if (board.errors == 0 && board.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
